// ===== sv/dfc_pkg.sv =====
// ----------------------------------------------------------------------------
// dfc_pkg - shared types for the direct-form FIR convolver
// Item kinds, controller states and the control bundle broadcast to the
// tap cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dfc_pkg;

  localparam int KIND_WIDTH    = 2;
  localparam int TAP_IDX_WIDTH = 7;
  localparam int CFG_WIDTH     = 8;

  // Input item kinds; the remaining code is ignored
  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_COEFF  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_PRIME1 = 2'd1,
    ST_PRIME2 = 2'd2,
    ST_RUN    = 2'd3
  } state_e;

  // Control broadcast to every tap cell
  typedef struct packed {
    logic shift;    // shift a new sample into the history chain
    logic clear;    // zero the history chain
    logic coef_we;  // write one coefficient, selected by tap index
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/dfc_tap_cell.sv =====
// ----------------------------------------------------------------------------
// dfc_tap_cell - one tap of the FIR chain
// Holds one history sample and one coefficient, forms their product and
// adds it to the partial sum that ripples down the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_tap_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 39,
  parameter int TAP_IDX      = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dfc_pkg::cell_ctl_t                   ctl_i,
  input  logic                                 tap_en_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       coeff_i,
  input  logic [dfc_pkg::TAP_IDX_WIDTH-1:0]    tap_index_i,
  input  logic signed [ACC_WIDTH-1:0]          psum_i,
  input  logic                                 psum_valid_i,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_o,
  output logic signed [ACC_WIDTH-1:0]          psum_o,
  output logic                                 psum_valid_o
);

  import dfc_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0]   hist_q;
  logic signed [SAMPLE_WIDTH-1:0]   coeff_q;
  logic signed [2*SAMPLE_WIDTH-1:0] prod_q;
  logic signed [ACC_WIDTH-1:0]      psum_q;
  logic                             psum_valid_q;
  logic signed [ACC_WIDTH-1:0]      addend;
  logic                             coef_hit;

  // History sample: clear, or take the neighbor's sample on a shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (ctl_i.clear) begin
      hist_q <= '0;
    end else if (ctl_i.shift) begin
      hist_q <= sample_i;
    end
  end

  // Coefficient: load when the write addresses this tap
  assign coef_hit = ctl_i.coef_we && (32'(tap_index_i) == 32'(TAP_IDX));

  always_ff @(posedge clk_i) begin
    if (coef_hit) begin
      coeff_q <= coeff_i;
    end
  end

  // Product of the held pair, refreshed every cycle
  always_ff @(posedge clk_i) begin
    prod_q <= hist_q * coeff_q;
  end

  // Skip taps beyond the active count
  assign addend = tap_en_i ? ACC_WIDTH'(prod_q) : '0;

  // Partial sum: add this tap and hand on
  always_ff @(posedge clk_i) begin
    if (psum_valid_i) begin
      psum_q <= psum_i + addend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_valid_q <= 1'b0;
    end else begin
      psum_valid_q <= psum_valid_i;
    end
  end

  assign sample_o     = hist_q;
  assign psum_o       = psum_q;
  assign psum_valid_o = psum_valid_q;

endmodule

`default_nettype wire

// ===== sv/dfc_round_sat.sv =====
// ----------------------------------------------------------------------------
// dfc_round_sat - rounding, saturation and output register
// Drops the fraction bits of the biased sum, clamps to the sample range and
// holds the result until the transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_round_sat #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 39
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic signed [ACC_WIDTH-1:0]    psum_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           clipped_o
);

  localparam int SH_WIDTH = ACC_WIDTH - SAMPLE_WIDTH + 1;

  localparam logic [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [SH_WIDTH-1:0]          shifted;
  logic                         in_range;
  logic [SAMPLE_WIDTH-1:0]      sat_val;
  logic                         out_valid_q;
  logic [SAMPLE_WIDTH-1:0]      sample_q;
  logic                         clipped_q;

  // Floor shift: the rounding bias is already in the sum
  assign shifted = psum_i[ACC_WIDTH-1:SAMPLE_WIDTH-1];

  // In range when all bits above the sample's sign agree with it
  assign in_range = (&shifted[SH_WIDTH-1:SAMPLE_WIDTH-1]) ||
                    !(|shifted[SH_WIDTH-1:SAMPLE_WIDTH-1]);

  always_comb begin
    if (in_range) begin
      sat_val = shifted[SAMPLE_WIDTH-1:0];
    end else if (shifted[SH_WIDTH-1]) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = SAT_MAX;
    end
  end

  // Output register: fill on load, drop after the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_q  <= sat_val;
      clipped_q <= !in_range;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;
  assign clipped_o    = clipped_q;

endmodule

`default_nettype wire

// ===== sv/direct_fir_convolver_core.sv =====
// ----------------------------------------------------------------------------
// direct_fir_convolver_core - direct-form FIR filter on a chain of tap cells
// Each tap cell holds one history sample and one coefficient; a partial sum
// walks down the chain, one cell per cycle, then is rounded and saturated.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   kind, sample_in, tap_index,
//                                                 coeff_value
//   out      output     out_valid_o / out_stall_i sample_out, clipped
//   cfg      input      cfg_we_i                  cfg_wdata_i (tap_count)
//
// Each sample's transfer shifts it into the history; the cells then form their
// products, the partial sum walks the whole chain and the result is rounded
// into the result register. The next sample can transfer only once the chain
// is done and the controller is back in idle. Coefficient writes and clears
// are taken in idle as well. A new sample waits only while the chain is busy
// or the result register is still full and stalled. Reset zeroes the history
// and sets tap_count to 1; coefficients hold no reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_fir_convolver_core #(
  parameter int MAX_TAPS     = 128,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [dfc_pkg::CFG_WIDTH-1:0]        cfg_wdata_i,
  // input items
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [dfc_pkg::KIND_WIDTH-1:0]       kind_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  input  logic [dfc_pkg::TAP_IDX_WIDTH-1:0]    tap_index_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       coeff_value_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out_o,
  output logic                                 clipped_o
);

  import dfc_pkg::*;

  localparam int ACC_FULL  = 2 * SAMPLE_WIDTH + $clog2(MAX_TAPS);
  localparam int ACC_WIDTH = (ACC_FULL > 64) ? 64 : ACC_FULL;

  localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
    ACC_WIDTH'(1) << (SAMPLE_WIDTH - 2);

  state_e                         state_q, state_d;
  logic [CFG_WIDTH-1:0]           tap_count_q;
  cell_ctl_t                      ctl;
  logic                           in_xfer;
  logic                           chain_done;
  logic                           chain_start;
  logic [MAX_TAPS-1:0]            tap_en;
  logic signed [SAMPLE_WIDTH-1:0] hist [MAX_TAPS];
  logic signed [ACC_WIDTH-1:0]    psum [MAX_TAPS+1];
  logic [MAX_TAPS:0]              psum_valid;

  // Tap count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= CFG_WIDTH'(1);
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_wdata_i;
    end
  end

  // Hold every new item while the chain works, and new samples while a result is stuck
  always_comb begin
    in_stall_o = (state_q != ST_IDLE) ||
                 ((kind_e'(kind_i) == KIND_SAMPLE) && out_valid_o && out_stall_i);
  end

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign chain_done = psum_valid[MAX_TAPS];

  // Controller state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and cell control
  always_comb begin
    state_d     = state_q;
    ctl         = '0;
    chain_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (kind_e'(kind_i))
            KIND_SAMPLE: begin
              ctl.shift = 1'b1;
              state_d   = ST_PRIME1;
            end
            KIND_COEFF: ctl.coef_we = 1'b1;
            KIND_CLEAR: ctl.clear   = 1'b1;
            default: ;
          endcase
        end
      end
      ST_PRIME1: state_d = ST_PRIME2;
      ST_PRIME2: begin
        chain_start = 1'b1;
        state_d     = ST_RUN;
      end
      ST_RUN: begin
        if (chain_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign psum_valid[0] = chain_start;
  assign hist[0]       = sample_in_i;
  assign psum[0]       = ROUND_BIAS;

  // Tap chain
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    assign tap_en[k] = (32'(tap_count_q) > 32'(k));

    if (k == MAX_TAPS - 1) begin : g_last
      dfc_tap_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH),
        .TAP_IDX      (k)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl),
        .tap_en_i     (tap_en[k]),
        .sample_i     (hist[k]),
        .coeff_i      (coeff_value_i),
        .tap_index_i  (tap_index_i),
        .psum_i       (psum[k]),
        .psum_valid_i (psum_valid[k]),
        .sample_o     (),
        .psum_o       (psum[k+1]),
        .psum_valid_o (psum_valid[k+1])
      );
    end else begin : g_mid
      dfc_tap_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH),
        .TAP_IDX      (k)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctl_i        (ctl),
        .tap_en_i     (tap_en[k]),
        .sample_i     (hist[k]),
        .coeff_i      (coeff_value_i),
        .tap_index_i  (tap_index_i),
        .psum_i       (psum[k]),
        .psum_valid_i (psum_valid[k]),
        .sample_o     (hist[k+1]),
        .psum_o       (psum[k+1]),
        .psum_valid_o (psum_valid[k+1])
      );
    end
  end

  // Round, saturate and hold the result
  dfc_round_sat #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_round_sat (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (chain_done),
    .psum_i       (psum[MAX_TAPS]),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o)
  );

endmodule

`default_nettype wire
